// ----- rtl/pidc_pkg.sv -----
// Shared types and constants for the clamped PID controller.
package pidc_pkg;

  localparam int unsigned GainWidth  = 16;
  localparam int unsigned DriveWidth = 32;
  localparam int unsigned CfgAddrWidth = 3;
  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned FracBits   = 8;

  typedef enum logic [CfgAddrWidth-1:0] {
    RegSetpoint = 3'd0,
    RegKp       = 3'd1,
    RegKi       = 3'd2,
    RegKd       = 3'd3,
    RegOutMax   = 3'd4,
    RegOutMin   = 3'd5
  } cfg_reg_e;

  // Gains and output limits used by the arithmetic back end.
  typedef struct packed {
    logic signed [GainWidth-1:0]  kp;
    logic signed [GainWidth-1:0]  ki;
    logic signed [GainWidth-1:0]  kd;
    logic signed [DriveWidth-1:0] out_max;
    logic signed [DriveWidth-1:0] out_min;
  } gain_cfg_t;

endpackage

// ----- rtl/pidc_fifo.sv -----
// Small register queue between the error front end and the arithmetic back end.
module pidc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntWidth = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_q [DEPTH];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] count_q, count_d;
  logic                do_push, do_pop;

  assign full_o     = (count_q == CntWidth'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/pidc_front.sv -----
// Front end: takes samples, forms error and difference, keeps the saturating error sum.
module pidc_front #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned SUM_WIDTH    = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic signed [SAMPLE_WIDTH-1:0] setpoint_i,
  input  logic                           take_i,
  input  logic signed [SAMPLE_WIDTH-1:0] measured_i,
  output logic signed [SAMPLE_WIDTH:0]   error_o,
  output logic signed [SAMPLE_WIDTH+1:0] diff_o,
  output logic signed [SUM_WIDTH-1:0]    sum_o
);

  localparam int unsigned EW  = SAMPLE_WIDTH + 1;
  localparam int unsigned SXW = ((SUM_WIDTH > EW) ? SUM_WIDTH : EW) + 1;

  logic signed [EW-1:0]        prev_q, prev_d;
  logic signed [SUM_WIDTH-1:0] sum_q, sum_d;
  logic signed [EW-1:0]        err;
  logic signed [SXW-1:0]       sum_wide;
  logic [SXW-SUM_WIDTH:0]      sum_top;

  assign err = $signed({measured_i[SAMPLE_WIDTH-1], measured_i})
             - $signed({setpoint_i[SAMPLE_WIDTH-1], setpoint_i});

  assign sum_wide = $signed({{(SXW-SUM_WIDTH){sum_q[SUM_WIDTH-1]}}, sum_q})
                  + $signed({{(SXW-EW){err[EW-1]}}, err});
  assign sum_top  = sum_wide[SXW-1:SUM_WIDTH-1];

  always_comb begin
    // Saturate the running sum when the bits above its sign disagree.
    if ((sum_top == '0) || (sum_top == '1)) begin
      sum_d = sum_wide[SUM_WIDTH-1:0];
    end else if (sum_wide[SXW-1]) begin
      sum_d = {1'b1, {(SUM_WIDTH-1){1'b0}}};
    end else begin
      sum_d = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end
    prev_d = err;
  end

  assign error_o = err;
  assign diff_o  = $signed({err[EW-1], err}) - $signed({prev_q[EW-1], prev_q});
  assign sum_o   = sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      sum_q  <= '0;
    end else if (take_i) begin
      prev_q <= prev_d;
      sum_q  <= sum_d;
    end
  end

endmodule

// ----- rtl/pidc_back.sv -----
// Back end: gain products, shift and saturate, optional clamp, output register.
module pidc_back #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned SUM_WIDTH    = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pidc_pkg::gain_cfg_t            cfg_i,
  input  logic                           q_valid_i,
  output logic                           q_pop_o,
  input  logic signed [SAMPLE_WIDTH:0]   error_i,
  input  logic signed [SAMPLE_WIDTH+1:0] diff_i,
  input  logic signed [SUM_WIDTH-1:0]    sum_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [pidc_pkg::DriveWidth-1:0] drive_o,
  output logic                           clamped_o
);

  localparam int unsigned GW  = pidc_pkg::GainWidth;
  localparam int unsigned OW  = pidc_pkg::DriveWidth;
  localparam int unsigned FB  = pidc_pkg::FracBits;
  localparam int unsigned EW  = SAMPLE_WIDTH + 1;
  localparam int unsigned DW  = SAMPLE_WIDTH + 2;
  localparam int unsigned PKW = GW + EW;
  localparam int unsigned PIW = GW + SUM_WIDTH;
  localparam int unsigned PDW = GW + DW;
  localparam int unsigned AW  = ((PIW > PDW) ? PIW : PDW) + 2;
  localparam int unsigned SHW = AW - FB;

  // Stage 1: products
  logic                  v1_q, v1_d;
  logic signed [PKW-1:0] pk_q, pk_d;
  logic signed [PIW-1:0] pi_q, pi_d;
  logic signed [PDW-1:0] pd_q, pd_d;
  // Stage 2: shifted and saturated sum
  logic                  v2_q, v2_d;
  logic signed [OW-1:0]  sat_q, sat_d;
  // Stage 3: output register
  logic                  v3_q, v3_d;
  logic signed [OW-1:0]  drive_q, drive_d;
  logic                  clamped_q, clamped_d;

  logic                  ready1, ready2, ready3;
  logic signed [AW-1:0]  acc;
  logic signed [SHW-1:0] shifted;
  logic [SHW-OW:0]       sh_top;
  logic signed [OW-1:0]  upper_lim;

  assign ready3  = !v3_q || out_ready_i;
  assign ready2  = !v2_q || ready3;
  assign ready1  = !v1_q || ready2;
  assign q_pop_o = q_valid_i && ready1;

  assign v1_d = ready1 ? q_valid_i : v1_q;
  assign v2_d = ready2 ? v1_q : v2_q;
  assign v3_d = ready3 ? v2_q : v3_q;

  assign pk_d = cfg_i.kp * error_i;
  assign pi_d = cfg_i.ki * sum_i;
  assign pd_d = cfg_i.kd * diff_i;

  assign acc = $signed({{(AW-PKW){pk_q[PKW-1]}}, pk_q})
             + $signed({{(AW-PIW){pi_q[PIW-1]}}, pi_q})
             + $signed({{(AW-PDW){pd_q[PDW-1]}}, pd_q});
  // Dropping the fraction bits of a two's complement value rounds toward minus infinity.
  assign shifted = acc[AW-1:FB];
  assign sh_top  = shifted[SHW-1:OW-1];

  always_comb begin
    if ((sh_top == '0) || (sh_top == '1)) begin
      sat_d = shifted[OW-1:0];
    end else if (shifted[SHW-1]) begin
      sat_d = {1'b1, {(OW-1){1'b0}}};
    end else begin
      sat_d = {1'b0, {(OW-1){1'b1}}};
    end
  end

  // Apply the upper limit first, then the lower one; skip both when the limits match.
  always_comb begin
    drive_d   = sat_q;
    clamped_d = 1'b0;
    upper_lim = sat_q;
    if (cfg_i.out_max != cfg_i.out_min) begin
      if (sat_q > cfg_i.out_max) begin
        upper_lim = cfg_i.out_max;
        clamped_d = 1'b1;
      end
      if (upper_lim < cfg_i.out_min) begin
        drive_d   = cfg_i.out_min;
        clamped_d = 1'b1;
      end else begin
        drive_d   = upper_lim;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      pk_q <= pk_d;
      pi_q <= pi_d;
      pd_q <= pd_d;
    end
    if (ready2 && v1_q) begin
      sat_q <= sat_d;
    end
    if (ready3 && v2_q) begin
      drive_q   <= drive_d;
      clamped_q <= clamped_d;
    end
  end

  assign out_valid_o = v3_q;
  assign drive_o     = drive_q;
  assign clamped_o   = clamped_q;

endmodule

// ----- rtl/pid_controller_clamped.sv -----
// Top level of the clamped positional PID controller.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i / in_ready_o  measured_i
//   out       output     out_valid_o / out_ready_i drive_o, clamped_o
//   cfg       input      cfg_we_i                 cfg_addr_i, cfg_data_i
//
// One sample is taken per cycle while in_ready_o is high; the error, difference and
// saturating sum update in the cycle of acceptance, so the sum recurrence sets that rate.
// When nothing stalls, the queue entry is written at the edge that takes a sample, then
// the product, shift/saturate and clamp/output registers load before out_valid_o rises.
// Reset clears the error history, the sum, the config registers, the valid flags and the queue.
// A stalled output backs up the three-stage pipe and then the two-entry queue
// before in_ready_o drops.
module pid_controller_clamped #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned SUM_WIDTH    = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [pidc_pkg::CfgAddrWidth-1:0]      cfg_addr_i,
  input  logic [pidc_pkg::CfgDataWidth-1:0]      cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]         measured_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [pidc_pkg::DriveWidth-1:0] drive_o,
  output logic                                   clamped_o
);

  localparam int unsigned EW     = SAMPLE_WIDTH + 1;
  localparam int unsigned DW     = SAMPLE_WIDTH + 2;
  localparam int unsigned QW     = EW + DW + SUM_WIDTH;
  localparam int unsigned QDepth = 2;
  localparam int unsigned GW     = pidc_pkg::GainWidth;
  localparam int unsigned OW     = pidc_pkg::DriveWidth;

  logic signed [SAMPLE_WIDTH-1:0] setpoint_q;
  pidc_pkg::gain_cfg_t            gcfg_q;

  logic                           take;
  logic                           q_full, q_valid, q_pop;
  logic [QW-1:0]                  q_wdata, q_rdata;
  logic signed [EW-1:0]           f_err;
  logic signed [DW-1:0]           f_diff;
  logic signed [SUM_WIDTH-1:0]    f_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= '0;
      gcfg_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        pidc_pkg::RegSetpoint: setpoint_q     <= cfg_data_i[SAMPLE_WIDTH-1:0];
        pidc_pkg::RegKp:       gcfg_q.kp      <= cfg_data_i[GW-1:0];
        pidc_pkg::RegKi:       gcfg_q.ki      <= cfg_data_i[GW-1:0];
        pidc_pkg::RegKd:       gcfg_q.kd      <= cfg_data_i[GW-1:0];
        pidc_pkg::RegOutMax:   gcfg_q.out_max <= cfg_data_i[OW-1:0];
        pidc_pkg::RegOutMin:   gcfg_q.out_min <= cfg_data_i[OW-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !q_full;
  assign take       = in_valid_i && !q_full;

  pidc_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .SUM_WIDTH   (SUM_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .setpoint_i(setpoint_q),
    .take_i    (take),
    .measured_i(measured_i),
    .error_o   (f_err),
    .diff_o    (f_diff),
    .sum_o     (f_sum)
  );

  assign q_wdata = {f_err, f_diff, f_sum};

  pidc_fifo #(
    .WIDTH(QW),
    .DEPTH(QDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (take),
    .push_data_i(q_wdata),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_data_o (q_rdata)
  );

  pidc_back #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .SUM_WIDTH   (SUM_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (gcfg_q),
    .q_valid_i  (q_valid),
    .q_pop_o    (q_pop),
    .error_i    (q_rdata[QW-1:DW+SUM_WIDTH]),
    .diff_i     (q_rdata[DW+SUM_WIDTH-1:SUM_WIDTH]),
    .sum_i      (q_rdata[SUM_WIDTH-1:0]),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .drive_o    (drive_o),
    .clamped_o  (clamped_o)
  );

endmodule

// ----- tb/pid_controller_clamped_tb.sv -----
// Self-checking testbench for the clamped PID controller: directed table, random phases, soak.
module pid_controller_clamped_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SampleW = 16;
  localparam logic [pidc_pkg::CfgAddrWidth-1:0] RegSpareLo = 3'd6;
  localparam logic [pidc_pkg::CfgAddrWidth-1:0] RegSpareHi = 3'd7;
  localparam logic signed [SampleW-1:0] MeasMax = 16'sh7FFF;
  localparam logic signed [SampleW-1:0] MeasMin = 16'sh8000;
  localparam longint S32Max = (longint'(1) <<< 31) - 1;
  localparam longint S32Min = -(longint'(1) <<< 31);
  localparam int unsigned RandomPhases = 8;
  localparam int unsigned PhaseItems = 80;
  localparam int unsigned CalmPhase = 4;
  localparam int unsigned StallAt = 230;
  localparam int unsigned StallCycles = 80;
  localparam int unsigned SoakRiseItems = 45;
  localparam int unsigned SoakFallItems = 45;
  localparam int unsigned SoakTail = 10;
  localparam int unsigned TailCycles = 8;

  typedef struct packed {
    logic signed [pidc_pkg::DriveWidth-1:0] drive;
    logic                                   clamped;
  } drive_result_t;

  typedef enum logic { RowCfg, RowSample } row_kind_e;

  typedef enum logic [1:0] { ModeWide, ModeGentle, ModeCorner, ModeTight } phase_mode_e;

  typedef struct {
    row_kind_e                             kind;
    logic [pidc_pkg::CfgAddrWidth-1:0]     addr;
    logic [pidc_pkg::CfgDataWidth-1:0]     data;
    logic signed [SampleW-1:0]             meas;
    bit                                    fixed;
    drive_result_t                         want;
  } stim_row_t;

  logic                                   clk_i = 1'b0;
  logic                                   rst_ni = 1'b0;
  logic                                   cfg_we_i = 1'b0;
  logic [pidc_pkg::CfgAddrWidth-1:0]      cfg_addr_i = '0;
  logic [pidc_pkg::CfgDataWidth-1:0]      cfg_data_i = '0;
  logic                                   in_valid_i = 1'b0;
  logic                                   in_ready_o;
  logic signed [SampleW-1:0]              measured_i = '0;
  logic                                   out_valid_o;
  logic                                   out_ready_i = 1'b0;
  logic signed [pidc_pkg::DriveWidth-1:0] drive_o;
  logic                                   clamped_o;

  // Shadow copy of the controller registers and history
  logic signed [SampleW-1:0]              sp_q = '0;
  logic signed [pidc_pkg::GainWidth-1:0]  kp_q = '0;
  logic signed [pidc_pkg::GainWidth-1:0]  ki_q = '0;
  logic signed [pidc_pkg::GainWidth-1:0]  kd_q = '0;
  logic signed [pidc_pkg::DriveWidth-1:0] hi_q = '0;
  logic signed [pidc_pkg::DriveWidth-1:0] lo_q = '0;
  logic signed [SampleW:0]                prev_err_q = '0;
  logic signed [31:0]                     err_sum_q = '0;

  drive_result_t expected_drives[$];
  drive_result_t no_want = '0;
  int unsigned   mismatches = 0;
  int unsigned   sent_total = 0;
  bit            calm = 1'b0;
  bit            stall_done = 1'b0;
  int unsigned   stall_left = 0;

  pid_controller_clamped #(
    .SAMPLE_WIDTH(SampleW),
    .SUM_WIDTH   (32)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .measured_i (measured_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .drive_o    (drive_o),
    .clamped_o  (clamped_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #(10_000_000);
    $display("pid_controller_clamped regression: fail");
    $finish;
  end

  // Advance the history and return the drive value for one sample
  function automatic drive_result_t next_drive(input logic signed [SampleW-1:0] m);
    longint        e;
    longint        diff;
    longint        total;
    longint        acc;
    longint        v;
    drive_result_t r;
    e = longint'(m) - longint'(sp_q);
    diff = e - longint'(prev_err_q);
    total = longint'(err_sum_q) + e;
    if (total > S32Max) total = S32Max;
    else if (total < S32Min) total = S32Min;
    err_sum_q = total[31:0];
    prev_err_q = e[SampleW:0];
    acc = longint'(kp_q) * e + longint'(ki_q) * total + longint'(kd_q) * diff;
    v = acc >>> pidc_pkg::FracBits;
    if (v > S32Max) v = S32Max;
    else if (v < S32Min) v = S32Min;
    r.clamped = 1'b0;
    if (hi_q != lo_q) begin
      if (v > longint'(hi_q)) begin
        v = longint'(hi_q);
        r.clamped = 1'b1;
      end
      if (v < longint'(lo_q)) begin
        v = longint'(lo_q);
        r.clamped = 1'b1;
      end
    end
    r.drive = v[31:0];
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [pidc_pkg::CfgAddrWidth-1:0] addr,
                                        input logic [pidc_pkg::CfgDataWidth-1:0] data);
    stim_row_t r;
    r.kind = RowCfg;
    r.addr = addr;
    r.data = data;
    r.meas = '0;
    r.fixed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t sample_row(input logic signed [SampleW-1:0] meas, input bit fixed,
                                           input logic signed [pidc_pkg::DriveWidth-1:0] drive,
                                           input logic clamped);
    stim_row_t r;
    r.kind = RowSample;
    r.addr = '0;
    r.data = '0;
    r.meas = meas;
    r.fixed = fixed;
    r.want.drive = drive;
    r.want.clamped = clamped;
    return r;
  endfunction

  function automatic logic [pidc_pkg::CfgDataWidth-1:0] small_gain();
    int g;
    g = int'($urandom_range(1536)) - 768;
    return g;
  endfunction

  function automatic logic [pidc_pkg::CfgDataWidth-1:0] extreme16();
    case ($urandom_range(4))
      0: return 32'h0000_7FFF;
      1: return 32'hFFFF_8000;
      2: return 32'h0000_0000;
      3: return 32'h0000_0001;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic signed [SampleW-1:0] pick_measured();
    int r;
    int t;
    r = $urandom_range(99);
    if (r < 70) return SampleW'($urandom);
    if (r < 85) return $urandom_range(1) ? MeasMax : MeasMin;
    t = int'(sp_q) + int'($urandom_range(16)) - 8;
    return t[SampleW-1:0];
  endfunction

  // Write one register at the next edge; the caller lowers the write enable
  task automatic cfg_write(input logic [pidc_pkg::CfgAddrWidth-1:0] addr,
                           input logic [pidc_pkg::CfgDataWidth-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (addr)
      pidc_pkg::RegSetpoint: sp_q = data[SampleW-1:0];
      pidc_pkg::RegKp:       kp_q = data[pidc_pkg::GainWidth-1:0];
      pidc_pkg::RegKi:       ki_q = data[pidc_pkg::GainWidth-1:0];
      pidc_pkg::RegKd:       kd_q = data[pidc_pkg::GainWidth-1:0];
      pidc_pkg::RegOutMax:   hi_q = data;
      pidc_pkg::RegOutMin:   lo_q = data;
      default: ;
    endcase
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_sample(input logic signed [SampleW-1:0] m, input bit fixed,
                             input drive_result_t want);
    drive_result_t pred;
    while (!calm && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    measured_i <= m;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pred = next_drive(m);
    expected_drives.insert(expected_drives.size(), fixed ? want : pred);
    sent_total++;
  endtask

  task automatic program_phase(input phase_mode_e mode);
    logic [pidc_pkg::CfgDataWidth-1:0] sp;
    logic [pidc_pkg::CfgDataWidth-1:0] kp;
    logic [pidc_pkg::CfgDataWidth-1:0] ki;
    logic [pidc_pkg::CfgDataWidth-1:0] kd;
    logic [pidc_pkg::CfgDataWidth-1:0] mx;
    logic [pidc_pkg::CfgDataWidth-1:0] mn;
    logic [pidc_pkg::CfgDataWidth-1:0] tmp;
    sp = $urandom;
    kp = small_gain();
    ki = small_gain();
    kd = small_gain();
    case (mode)
      ModeWide: begin
        kp = $urandom;
        ki = $urandom;
        kd = $urandom;
        mx = $urandom;
        mn = $urandom;
      end
      ModeGentle: begin
        mx = $urandom_range(200000);
        mn = -int'($urandom_range(200000));
      end
      ModeCorner: begin
        sp = extreme16();
        kp = extreme16();
        ki = extreme16();
        kd = extreme16();
        case ($urandom_range(2))
          0: begin
            mx = 32'h7FFF_FFFF;
            mn = 32'h8000_0000;
          end
          1: begin
            mx = $urandom;
            mn = mx;
          end
          default: begin
            mx = 32'h8000_0000;
            mn = 32'h7FFF_FFFF;
          end
        endcase
      end
      default: begin
        mx = $urandom_range(3000);
        mn = -int'($urandom_range(3000));
        // cross or collapse the window now and then
        if ($urandom_range(3) == 0) begin
          tmp = mx;
          mx = mn;
          mn = tmp;
        end else if ($urandom_range(5) == 0) begin
          mn = mx;
        end
      end
    endcase
    cfg_write(pidc_pkg::RegSetpoint, sp);
    cfg_write(pidc_pkg::RegKp, kp);
    cfg_write(pidc_pkg::RegKi, ki);
    cfg_write(pidc_pkg::RegKd, kd);
    cfg_write(pidc_pkg::RegOutMax, mx);
    cfg_write(pidc_pkg::RegOutMin, mn);
    cfg_we_i <= 1'b0;
  endtask

  // Output side: random back-pressure plus one long hold-off
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!stall_done && sent_total >= StallAt) begin
      stall_done <= 1'b1;
      stall_left <= StallCycles;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= 11);
    end
  end

  always @(posedge clk_i) begin
    drive_result_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_drives.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected transaction: drive=%0d clamped=%0b", drive_o, clamped_o);
        mismatches++;
      end else begin
        w = expected_drives.pop_front();
        if (w.drive !== drive_o || w.clamped !== clamped_o) begin
          if (mismatches < 10)
            $display("mismatch: expected drive=%0d clamped=%0b, got drive=%0d clamped=%0b",
                     w.drive, w.clamped, drive_o, clamped_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    stim_row_t   rows[$];
    int unsigned n;
    logic signed [SampleW-1:0] m;

    // after reset every gain is zero
    rows.insert(rows.size(), sample_row(MeasMax, 1'b1, 32'sd0, 1'b0));
    rows.insert(rows.size(), sample_row(MeasMin, 1'b1, 32'sd0, 1'b0));
    // unity proportional gain with a +/-1000 window
    rows.insert(rows.size(), cfg_row(pidc_pkg::RegKp, 32'd256));
    rows.insert(rows.size(), cfg_row(pidc_pkg::RegOutMax, 32'd1000));
    rows.insert(rows.size(), cfg_row(pidc_pkg::RegOutMin, -32'sd1000));
    rows.insert(rows.size(), sample_row(16'sd500, 1'b1, 32'sd500, 1'b0));
    rows.insert(rows.size(), sample_row(16'sd2000, 1'b1, 32'sd1000, 1'b1));
    rows.insert(rows.size(), sample_row(MeasMin, 1'b1, -32'sd1000, 1'b1));
    // equal limits disable the clamp
    rows.insert(rows.size(), cfg_row(pidc_pkg::RegOutMax, 32'd5));
    rows.insert(rows.size(), cfg_row(pidc_pkg::RegOutMin, 32'd5));
    rows.insert(rows.size(), sample_row(MeasMax, 1'b1, 32'sd32767, 1'b0));
    rows.insert(rows.size(), cfg_row(pidc_pkg::RegSetpoint, 32'hFFFF_8000));
    rows.insert(rows.size(), sample_row(MeasMax, 1'b1, 32'sd65535, 1'b0));
    // crossed limits always land on the lower one
    rows.insert(rows.size(), cfg_row(pidc_pkg::RegOutMax, -32'sd10));
    rows.insert(rows.size(), cfg_row(pidc_pkg::RegOutMin, 32'd10));
    rows.insert(rows.size(), sample_row(MeasMax, 1'b1, 32'sd10, 1'b1));
    rows.insert(rows.size(), sample_row(MeasMin, 1'b1, 32'sd10, 1'b1));
    rows.insert(rows.size(), cfg_row(pidc_pkg::RegSetpoint, 32'd0));
    rows.insert(rows.size(), sample_row(-16'sd100, 1'b1, 32'sd10, 1'b1));
    // extreme gains, checked against the predictor
    rows.insert(rows.size(), cfg_row(pidc_pkg::RegKi, 32'h0000_7FFF));
    rows.insert(rows.size(), cfg_row(pidc_pkg::RegKd, 32'hFFFF_8000));
    rows.insert(rows.size(), cfg_row(pidc_pkg::RegKp, 32'hFFFF_8000));
    rows.insert(rows.size(), cfg_row(pidc_pkg::RegOutMax, 32'd0));
    rows.insert(rows.size(), cfg_row(pidc_pkg::RegOutMin, 32'd0));
    rows.insert(rows.size(), sample_row(MeasMax, 1'b0, 32'sd0, 1'b0));
    rows.insert(rows.size(), sample_row(MeasMin, 1'b0, 32'sd0, 1'b0));
    rows.insert(rows.size(), sample_row(16'sd0, 1'b0, 32'sd0, 1'b0));
    rows.insert(rows.size(), sample_row(16'sd1, 1'b0, 32'sd0, 1'b0));
    // writes to unmapped indexes must not disturb anything
    rows.insert(rows.size(), cfg_row(RegSpareLo, 32'hDEAD_BEEF));
    rows.insert(rows.size(), cfg_row(RegSpareHi, 32'h1234_5678));
    rows.insert(rows.size(), sample_row(16'sd12345, 1'b0, 32'sd0, 1'b0));
    // zero gains give zero drive
    rows.insert(rows.size(), cfg_row(pidc_pkg::RegKp, 32'd0));
    rows.insert(rows.size(), cfg_row(pidc_pkg::RegKi, 32'd0));
    rows.insert(rows.size(), cfg_row(pidc_pkg::RegKd, 32'd0));
    rows.insert(rows.size(), sample_row(MeasMax, 1'b1, 32'sd0, 1'b0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].kind == RowCfg) begin
        drain_results();
        cfg_write(rows[i].addr, rows[i].data);
      end else begin
        cfg_we_i <= 1'b0;
        send_sample(rows[i].meas, rows[i].fixed, rows[i].want);
      end
    end

    for (int p = 0; p < RandomPhases; p++) begin
      drain_results();
      calm = (p == CalmPhase);
      program_phase(phase_mode_e'(p % 4));
      for (int i = 0; i < PhaseItems; i++) send_sample(pick_measured(), 1'b0, no_want);
    end

    // push the error sum hard in each direction
    for (int pass = 0; pass < 2; pass++) begin
      drain_results();
      calm = 1'b0;
      cfg_write(pidc_pkg::RegSetpoint, (pass == 0) ? 32'hFFFF_8000 : 32'h0000_7FFF);
      cfg_write(pidc_pkg::RegKi, 32'h0000_7FFF);
      cfg_write(pidc_pkg::RegKp, small_gain());
      cfg_write(pidc_pkg::RegKd, extreme16());
      cfg_write(pidc_pkg::RegOutMax, (pass == 0) ? 32'h7FFF_FFFF : 32'd0);
      cfg_write(pidc_pkg::RegOutMin, (pass == 0) ? 32'h8000_0000 : 32'd0);
      cfg_we_i <= 1'b0;
      n = (pass == 0) ? SoakRiseItems : SoakFallItems;
      for (int i = 0; i < n; i++) begin
        m = (pass == 0) ? MeasMax : MeasMin;
        send_sample((i < n - SoakTail) ? m : pick_measured(), 1'b0, no_want);
      end
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_drives.size() == 0) begin
      $display("pid_controller_clamped regression: pass");
    end else begin
      $display("pid_controller_clamped regression: fail");
    end
    $finish;
  end

endmodule

// ----- pid_controller_clamped.f -----
rtl/pidc_pkg.sv
rtl/pidc_fifo.sv
rtl/pidc_front.sv
rtl/pidc_back.sv
rtl/pid_controller_clamped.sv
tb/pid_controller_clamped_tb.sv
